[rtl/rect_polar_converter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rectangular/polar converter
// Each macro samples on the rising edge of clock and is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RECT_POLAR_CONVERTER_ASSERT_SVH
`define RECT_POLAR_CONVERTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, angle constants and the arctangent table of the converter.
// ----------------------------------------------------------------------------
package rpc_pkg;

   localparam int XW = 64;   // CORDIC x/y datapath, Q46
   localparam int ZW = 32;   // angle accumulator, degrees scaled by 2^20
   localparam int QW = 32;   // Q16.16 word

   localparam logic signed [QW-1:0] DEG90  = 32'sd5898240;
   localparam logic signed [QW-1:0] DEG180 = 32'sd11796480;
   localparam logic signed [QW-1:0] DEG270 = 32'sd17694720;
   localparam logic signed [QW-1:0] DEG360 = 32'sd23592960;

   // Inverse CORDIC gain, Q30.
   localparam logic signed [QW-1:0] INV_GAIN_Q30 = 32'sd652032874;

   typedef enum logic [1:0] {
      OP_RECT    = 2'd0,
      OP_P2R     = 2'd1,
      OP_R2P     = 2'd2,
      OP_INVALID = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_HOLD   = 2'd0,
      MODE_ROTATE = 2'd1,
      MODE_VECTOR = 2'd2
   } cell_mode_type;

   typedef enum logic [1:0] {
      BASE_ZERO = 2'd0,
      BASE_POS  = 2'd1,
      BASE_NEG  = 2'd2
   } base_type;

   typedef struct packed {
      cell_mode_type          mode;
      base_type               base;
      logic                   sat;
      logic signed [XW-1:0]   x;
      logic signed [XW-1:0]   y;
      logic signed [ZW-1:0]   z;
   } cordic_type;

   // atan(2^-i) in degrees times 2^20, rounded to nearest.
   function automatic logic signed [ZW-1:0] atan_deg20(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:       val = 32'sd47185920;
         1:       val = 32'sd27855475;
         2:       val = 32'sd14718068;
         3:       val = 32'sd7471121;
         4:       val = 32'sd3750058;
         5:       val = 32'sd1876857;
         6:       val = 32'sd938658;
         7:       val = 32'sd469357;
         8:       val = 32'sd234682;
         9:       val = 32'sd117342;
         10:      val = 32'sd58671;
         11:      val = 32'sd29335;
         12:      val = 32'sd14668;
         13:      val = 32'sd7334;
         14:      val = 32'sd3667;
         15:      val = 32'sd1833;
         16:      val = 32'sd917;
         17:      val = 32'sd458;
         18:      val = 32'sd229;
         19:      val = 32'sd115;
         20:      val = 32'sd57;
         21:      val = 32'sd29;
         22:      val = 32'sd14;
         23:      val = 32'sd7;
         24:      val = 32'sd4;
         25:      val = 32'sd2;
         26:      val = 32'sd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

[rtl/rpc_channel_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc channel interfaces
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface rpc_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic signed [31:0] first_value;
   logic signed [31:0] second_value;

   modport source (output valid, operation, first_value, second_value, input ready);
   modport sink (input valid, operation, first_value, second_value, output ready);
endinterface

interface rpc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_result;
   logic signed [31:0] second_result;
   logic               saturated;

   modport source (output valid, first_result, second_result, saturated, input ready);
   modport sink (input valid, first_result, second_result, saturated, output ready);
endinterface

[rtl/rpc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_front
// Four pipeline stages ahead of the CORDIC cells: angle reduction, special
// case handling, gain scaling and setup of the cell beat.
// ----------------------------------------------------------------------------
`include "rect_polar_converter_assert.svh"

module rpc_front
   import rpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   rpc_req_if.sink    req_channel,
   output logic       dn_valid,
   input  logic       dn_ready,
   output cordic_type dn_data
);

   localparam int QUOT_W = 8;
   // floor(u / 360) = (u * RECIP_360) >> RECIP_SHIFT, exact for 16-bit u.
   localparam logic [15:0] RECIP_360   = 16'd46604;
   localparam int          RECIP_SHIFT = 24;
   localparam logic [8:0]  TURN_DEG    = 9'd360;
   // The upper half is biased by 32768, which is 8 modulo 360.
   localparam logic [8:0]  BIAS_MOD    = 9'd8;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic [QUOT_W-1:0]  quot;
   } s0_type;

   typedef struct packed {
      cell_mode_type      mode;
      base_type           base;
      logic               sat;
      logic               neg;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic [24:0]        r0;
      logic signed [31:0] hold1;
      logic signed [31:0] hold2;
   } s1_type;

   typedef struct packed {
      cell_mode_type        mode;
      base_type             base;
      logic                 sat;
      logic                 neg;
      logic signed [XW-1:0] pa;
      logic signed [XW-1:0] pb;
      logic signed [ZW-1:0] r;
      logic signed [31:0]   hold1;
      logic signed [31:0]   hold2;
   } s2_type;

   s0_type     s0_ff, s0_in;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   cordic_type s3_ff, s3_in;
   logic       v0_ff, v1_ff, v2_ff, v3_ff;
   logic       v0_in, v1_in, v2_in, v3_in;
   logic       rdy0, rdy1, rdy2, rdy3;

   logic [15:0]          u0_w, u1_w;
   logic [31:0]          quot_prod_w;
   logic [16:0]          rem_w;
   logic [8:0]           hmod_w;
   logic [32:0]          abs_a_w, abs_b_w;
   logic signed [ZW-1:0] r0_w;

   // Returns {clamped, |v|} with |v| limited to the positive Q16.16 range.
   function automatic logic [32:0] abs_clamp(input logic signed [31:0] v);
      logic [32:0] res;
      if (v == 32'sh8000_0000) begin
         res = {1'b1, 32'h7FFF_FFFF};
      end else if (v < 0) begin
         res = {1'b0, 32'(-v)};
      end else begin
         res = {1'b0, v};
      end
      return res;
   endfunction

   assign rdy3 = !v3_ff || dn_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign v0_in = rdy0 ? req_channel.valid : v0_ff;
   assign v1_in = rdy1 ? v0_ff : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   assign req_channel.ready = rdy0;
   assign dn_valid          = v3_ff;
   assign dn_data           = s3_ff;

   // Stage 0: quotient of the biased upper half by 360.
   always_comb begin
      u0_w        = {~req_channel.second_value[31], req_channel.second_value[30:16]};
      quot_prod_w = 32'(u0_w) * 32'(RECIP_360);
      s0_in.op    = op_type'(req_channel.operation);
      s0_in.a     = req_channel.first_value;
      s0_in.b     = req_channel.second_value;
      s0_in.quot  = quot_prod_w[RECIP_SHIFT +: QUOT_W];
   end

   // Stage 1: angle modulo 360 and the cases that skip the CORDIC.
   always_comb begin
      u1_w  = {~s0_ff.b[31], s0_ff.b[30:16]};
      rem_w = 17'(u1_w) - (17'(s0_ff.quot) * 17'(TURN_DEG));
      if (rem_w >= 17'(TURN_DEG)) begin
         rem_w = rem_w - 17'(TURN_DEG);
      end
      if (rem_w[8:0] >= BIAS_MOD) begin
         hmod_w = rem_w[8:0] - BIAS_MOD;
      end else begin
         hmod_w = rem_w[8:0] + (TURN_DEG - BIAS_MOD);
      end
      abs_a_w = abs_clamp(s0_ff.a);
      abs_b_w = abs_clamp(s0_ff.b);

      s1_in       = '0;
      s1_in.a     = s0_ff.a;
      s1_in.b     = s0_ff.b;
      s1_in.r0    = {hmod_w, s0_ff.b[15:0]};
      s1_in.mode  = MODE_HOLD;
      s1_in.base  = BASE_ZERO;
      unique case (s0_ff.op)
         OP_RECT: begin
            s1_in.hold1 = s0_ff.a;
            s1_in.hold2 = s0_ff.b;
         end
         OP_P2R: begin
            s1_in.mode = MODE_ROTATE;
         end
         OP_R2P: begin
            if (s0_ff.a == 0 && s0_ff.b == 0) begin
               s1_in.hold1 = '0;
               s1_in.hold2 = '0;
            end else if (s0_ff.b == 0) begin
               s1_in.hold1 = $signed(abs_a_w[31:0]);
               s1_in.sat   = abs_a_w[32];
               s1_in.hold2 = (s0_ff.a > 0) ? 32'sd0 : DEG180;
            end else if (s0_ff.a == 0) begin
               s1_in.hold1 = $signed(abs_b_w[31:0]);
               s1_in.sat   = abs_b_w[32];
               s1_in.hold2 = (s0_ff.b > 0) ? DEG90 : -DEG90;
            end else begin
               // Left half plane is reflected through the origin.
               s1_in.mode = MODE_VECTOR;
               s1_in.neg  = s0_ff.a < 0;
               if (s0_ff.a < 0) begin
                  s1_in.base = (s0_ff.b >= 0) ? BASE_POS : BASE_NEG;
               end
            end
         end
         OP_INVALID: begin
            s1_in.hold1 = '0;
            s1_in.hold2 = '0;
         end
      endcase
   end

   // Stage 2: gain scaling and folding of the angle into [-90, 90].
   always_comb begin
      r0_w     = $signed(32'(s1_ff.r0));
      s2_in.mode  = s1_ff.mode;
      s2_in.base  = s1_ff.base;
      s2_in.sat   = s1_ff.sat;
      s2_in.hold1 = s1_ff.hold1;
      s2_in.hold2 = s1_ff.hold2;
      s2_in.pa    = 64'(s1_ff.a) * 64'(INV_GAIN_Q30);
      s2_in.pb    = 64'(s1_ff.b) * 64'(INV_GAIN_Q30);
      s2_in.neg   = s1_ff.neg;
      s2_in.r     = '0;
      if (s1_ff.mode == MODE_ROTATE) begin
         if (r0_w <= DEG90) begin
            s2_in.r   = r0_w;
            s2_in.neg = 1'b0;
         end else if (r0_w < DEG270) begin
            // Beyond a quarter turn: rotate by half a turn, negate magnitude.
            s2_in.r   = r0_w - DEG180;
            s2_in.neg = 1'b1;
         end else begin
            s2_in.r   = r0_w - DEG360;
            s2_in.neg = 1'b0;
         end
      end
   end

   // Stage 3: initial vector and angle for the cells.
   always_comb begin
      s3_in      = '0;
      s3_in.mode = s2_ff.mode;
      s3_in.base = s2_ff.base;
      s3_in.sat  = s2_ff.sat;
      case (s2_ff.mode)
         MODE_ROTATE: begin
            s3_in.x = s2_ff.neg ? -s2_ff.pa : s2_ff.pa;
            s3_in.y = '0;
            s3_in.z = s2_ff.r <<< 4;
         end
         MODE_VECTOR: begin
            s3_in.x = s2_ff.neg ? -s2_ff.pa : s2_ff.pa;
            s3_in.y = s2_ff.neg ? -s2_ff.pb : s2_ff.pb;
            s3_in.z = '0;
         end
         default: begin
            s3_in.x = 64'(s2_ff.hold1);
            s3_in.y = 64'(s2_ff.hold2);
            s3_in.z = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_channel.valid && rdy0) begin
         s0_ff <= s0_in;
      end
      if (v0_ff && rdy1) begin
         s1_ff <= s1_in;
      end
      if (v1_ff && rdy2) begin
         s2_ff <= s2_in;
      end
      if (v2_ff && rdy3) begin
         s3_ff <= s3_in;
      end
   end

   `RPC_ASSERT_SAME(fold_range, v2_ff && s2_ff.mode == MODE_ROTATE, s2_ff.r >= -DEG90 && s2_ff.r <= DEG90, "folded angle outside a quarter turn")

endmodule

[rtl/rpc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_cell
// One CORDIC micro-rotation with its own pipeline register.
// ----------------------------------------------------------------------------
`include "rect_polar_converter_assert.svh"

module rpc_cell
   import rpc_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  cordic_type up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output cordic_type dn_data
);

   localparam logic signed [ZW-1:0] ATAN_STEP = atan_deg20(SHIFT);

   cordic_type           data_ff, data_in;
   logic                 valid_ff, valid_in;
   logic signed [XW-1:0] x_w, y_w, dx_w, dy_w;
   logic signed [ZW-1:0] z_w;
   logic                 dir_w;

   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      x_w  = up_data.x;
      y_w  = up_data.y;
      z_w  = up_data.z;
      dx_w = y_w >>> SHIFT;
      dy_w = x_w >>> SHIFT;
      // Rotation drives the angle to zero; vectoring drives y to zero.
      case (up_data.mode)
         MODE_ROTATE: dir_w = (z_w >= 0);
         MODE_VECTOR: dir_w = (y_w < 0);
         default:     dir_w = 1'b0;
      endcase
      data_in = up_data;
      if (up_data.mode != MODE_HOLD) begin
         if (dir_w) begin
            data_in.x = x_w - dx_w;
            data_in.y = y_w + dy_w;
            data_in.z = z_w - ATAN_STEP;
         end else begin
            data_in.x = x_w + dx_w;
            data_in.y = y_w - dy_w;
            data_in.z = z_w + ATAN_STEP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   `RPC_ASSERT_NEXT(hold_passes, up_valid && up_ready && up_data.mode == MODE_HOLD, dn_data.x == $past(up_data.x) && dn_data.y == $past(up_data.y), "held beat altered by a cell")

endmodule

[rtl/rpc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_back
// Rounding to Q16.16, saturation, angle offset and wrap, and the response
// register that drives the output channel.
// ----------------------------------------------------------------------------
`include "rect_polar_converter_assert.svh"

module rpc_back
   import rpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       up_valid,
   output logic       up_ready,
   input  cordic_type up_data,
   rpc_rsp_if.source  rsp_channel
);

   localparam logic signed [XW-1:0]   ROUND_Q46 = 64'sd536870912;
   localparam logic signed [ZW-1:0]   ROUND_Z   = 32'sd8;
   localparam logic signed [QW+1:0]   SAT_HI    = 34'sd2147483647;
   localparam logic signed [QW+1:0]   SAT_LO    = -34'sd2147483648;

   typedef struct packed {
      cell_mode_type        mode;
      base_type             base;
      logic                 sat;
      logic signed [QW+1:0] xr;
      logic signed [QW+1:0] yr;
      logic signed [ZW-5:0] zr;
   } f0_type;

   f0_type               f0_ff, f0_in;
   logic                 f0_valid_ff, f0_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic signed [QW-1:0] first_ff, first_in;
   logic signed [QW-1:0] second_ff, second_in;
   logic                 sat_ff, sat_in;
   logic                 out_ready_w;

   logic signed [XW-1:0] xs_w, ys_w;
   logic signed [ZW-1:0] zs_w, ang_w;
   logic [QW:0]          cx_w, cy_w;

   function automatic logic [QW:0] clamp_q16(input logic signed [QW+1:0] v);
      logic [QW:0] res;
      if (v > SAT_HI) begin
         res = {1'b1, SAT_HI[QW-1:0]};
      end else if (v < SAT_LO) begin
         res = {1'b1, SAT_LO[QW-1:0]};
      end else begin
         res = {1'b0, v[QW-1:0]};
      end
      return res;
   endfunction

   assign out_ready_w  = !out_valid_ff || rsp_channel.ready;
   assign up_ready     = !f0_valid_ff || out_ready_w;
   assign f0_valid_in  = up_ready ? up_valid : f0_valid_ff;
   assign out_valid_in = out_ready_w ? f0_valid_ff : out_valid_ff;

   assign rsp_channel.valid         = out_valid_ff;
   assign rsp_channel.first_result  = first_ff;
   assign rsp_channel.second_result = second_ff;
   assign rsp_channel.saturated     = sat_ff;

   // Round half up: Q46 to Q16.16 and angle from 2^20 to 2^16 scale; held beats pass x and y unrounded.
   always_comb begin
      xs_w       = up_data.x + ROUND_Q46;
      ys_w       = up_data.y + ROUND_Q46;
      zs_w       = up_data.z + ROUND_Z;
      f0_in.mode = up_data.mode;
      f0_in.base = up_data.base;
      f0_in.sat  = up_data.sat;
      f0_in.zr   = $signed(zs_w[ZW-1:4]);
      if (up_data.mode == MODE_HOLD) begin
         f0_in.xr = {{2{up_data.x[QW-1]}}, up_data.x[QW-1:0]};
         f0_in.yr = {{2{up_data.y[QW-1]}}, up_data.y[QW-1:0]};
      end else begin
         f0_in.xr = $signed(xs_w[XW-1:30]);
         f0_in.yr = $signed(ys_w[XW-1:30]);
      end
   end

   always_comb begin
      cx_w  = clamp_q16(f0_ff.xr);
      cy_w  = clamp_q16(f0_ff.yr);
      ang_w = 32'(f0_ff.zr);
      case (f0_ff.base)
         BASE_POS: ang_w = ang_w + DEG180;
         BASE_NEG: ang_w = ang_w - DEG180;
         default:  ang_w = ang_w;
      endcase
      if (ang_w > DEG180) begin
         ang_w = ang_w - DEG360;
      end else if (ang_w <= -DEG180) begin
         ang_w = ang_w + DEG360;
      end
      case (f0_ff.mode)
         MODE_ROTATE: begin
            first_in  = $signed(cx_w[QW-1:0]);
            second_in = $signed(cy_w[QW-1:0]);
            sat_in    = cx_w[QW] || cy_w[QW];
         end
         MODE_VECTOR: begin
            first_in  = $signed(cx_w[QW-1:0]);
            second_in = ang_w;
            sat_in    = cx_w[QW];
         end
         default: begin
            first_in  = f0_ff.xr[QW-1:0];
            second_in = f0_ff.yr[QW-1:0];
            sat_in    = f0_ff.sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f0_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         f0_valid_ff  <= f0_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         f0_ff <= f0_in;
      end
      if (f0_valid_ff && out_ready_w) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         sat_ff    <= sat_in;
      end
   end

   `RPC_ASSERT_NEXT(vec_angle_range, f0_valid_ff && out_ready_w && f0_ff.mode == MODE_VECTOR, rsp_channel.second_result > -DEG180 && rsp_channel.second_result <= DEG180, "vectoring angle outside half a turn")
   `RPC_ASSERT_NEXT(vec_mag_sign, f0_valid_ff && out_ready_w && f0_ff.mode == MODE_VECTOR, rsp_channel.first_result >= 0, "vectoring magnitude is negative")

endmodule

[rtl/rect_polar_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_polar_converter
// Rectangular/polar conversion of Q16.16 vectors by a chain of CORDIC cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_channel carries one beat per conversion: operation, first_value
//   (x or magnitude) and second_value (y or angle in degrees, Q16.16).
//   rsp_channel returns one beat per request in request order: first_result,
//   second_result and the saturated flag.
//   The path from request to response runs through four setup stages
//   (angle reduction, special cases, gain multiply, vector setup), one
//   register per CORDIC iteration, and two output stages.
//   Throughput is one beat per cycle; every stage is a register, so a new
//   request is taken in every cycle while the response side keeps up.
//   When the receiver stalls, each stage holds only if its successor is
//   full, so bubbles close up and up to ITERATIONS + 6 beats are in flight
//   before req_channel.ready drops.
//   Reset clears every stage valid; no beats survive reset.
// ----------------------------------------------------------------------------
module rect_polar_converter
   import rpc_pkg::*;
#(
   parameter int ITERATIONS = 24
) (
   input logic        clock,
   input logic        reset,
   rpc_req_if.sink    req_channel,
   rpc_rsp_if.source  rsp_channel
);

   logic [ITERATIONS:0] link_valid;
   logic [ITERATIONS:0] link_ready;
   cordic_type          link_data [0:ITERATIONS];

   rpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_channel (req_channel),
      .dn_valid    (link_valid[0]),
      .dn_ready    (link_ready[0]),
      .dn_data     (link_data[0])
   );

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      rpc_cell #(
         .SHIFT (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (link_valid[k]),
         .up_ready (link_ready[k]),
         .up_data  (link_data[k]),
         .dn_valid (link_valid[k+1]),
         .dn_ready (link_ready[k+1]),
         .dn_data  (link_data[k+1])
      );
   end

   rpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (link_valid[ITERATIONS]),
      .up_ready    (link_ready[ITERATIONS]),
      .up_data     (link_data[ITERATIONS]),
      .rsp_channel (rsp_channel)
   );

endmodule
